/* src/ale_pkg.sv */
// Shared constants for the array list engine: field widths, operation
// kinds and status codes. No dependencies.
`timescale 1ns / 1ps

package ale_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 7;
  localparam int KIND_W       = 2;
  localparam int STAT_W       = 2;
  localparam int CAPACITY_DEF = 64;

  // operation kinds
  localparam logic [KIND_W-1:0] KIND_GET    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOCATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

endpackage

/* src/array_list_engine_unit.sv */
// Top level of the array list engine: sequencer, list length and the
// element store. Depends on ale_pkg and ale_ram.
`timescale 1ns / 1ps

// An ordered list of up to CAPACITY 32-bit values. Raise start for one
// cycle with busy low to issue an operation (get, locate, insert, delete);
// busy stays high until the result appears for exactly one cycle with
// out_valid high. The receiver cannot stall, so capture it then. All
// operations go through a single-read, single-write element store, one
// entry per cycle; insert and delete shift the entries behind the given
// position one place over. Rejected items (bad position, full list) answer
// straight from idle without touching the store. A new item can be issued
// in the cycle that out_valid is high.
module array_list_engine_unit #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ale_pkg::KIND_W-1:0]   in_kind,
  input  logic [ale_pkg::POS_W-1:0]    in_position,
  input  logic signed [ale_pkg::DATA_W-1:0] in_value,
  output logic                         out_valid,
  output logic [ale_pkg::STAT_W-1:0]   out_status,
  output logic signed [ale_pkg::DATA_W-1:0] out_read_value,
  output logic [ale_pkg::POS_W-1:0]    out_found_position,
  output logic [ale_pkg::POS_W-1:0]    out_length
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > ale_pkg::POS_W) ? LW : ale_pkg::POS_W;
  localparam logic [LW-1:0] CAP_LEN = LW'(CAPACITY);

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_GET_RD  = 3'd1;
  localparam logic [2:0] S_GET_OUT = 3'd2;
  localparam logic [2:0] S_LOC     = 3'd3;
  localparam logic [2:0] S_SHIFT   = 3'd4;
  localparam logic [2:0] S_FILL    = 3'd5;

  logic [2:0]                   state_r, state_nxt;
  logic [LW-1:0]                len_r, len_nxt;
  logic [ale_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [ale_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [ale_pkg::DATA_W-1:0]   val_r, val_nxt;
  logic [AW-1:0]                ptr_r, ptr_nxt;
  logic [LW-1:0]                rem_r, rem_nxt;
  logic                         pend_r, pend_nxt;
  logic [AW-1:0]                pend_addr_r, pend_addr_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [ale_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [ale_pkg::DATA_W-1:0]   out_rd_r, out_rd_nxt;
  logic [ale_pkg::POS_W-1:0]    out_found_r, out_found_nxt;
  logic [ale_pkg::POS_W-1:0]    out_len_r, out_len_nxt;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [ale_pkg::DATA_W-1:0]   mem_wdata;
  logic [ale_pkg::DATA_W-1:0]   mem_rdata;

  // position checks against the current length, at a common width
  logic [CW-1:0] posw, lenw, posm1, lenm1, pos_r_m1;
  logic          pos_zero, pos_over, ins_over, list_full;
  logic [CW-1:0] ins_moves, del_moves, found_w;

  assign posw      = CW'(in_position);
  assign lenw      = CW'(len_r);
  assign posm1     = posw - CW'(1);
  assign lenm1     = lenw - CW'(1);
  assign pos_r_m1  = CW'(pos_r) - CW'(1);
  assign pos_zero  = (in_position == '0);
  assign pos_over  = (posw > lenw);
  assign ins_over  = (posm1 > lenw);
  assign list_full = (len_r == CAP_LEN);
  assign ins_moves = lenw - posm1;
  assign del_moves = lenw - posw;
  assign found_w   = CW'(pend_addr_r) + CW'(1);

  ale_ram #(
    .WIDTH(ale_pkg::DATA_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(ptr_r),
    .rdata(mem_rdata)
  );

  // sequencer
  always_comb begin
    logic          fin;
    logic [LW-1:0] fin_len;
    logic [CW-1:0] fin_len_w;
    fin            = 1'b0;
    fin_len        = len_r;
    fin_len_w      = '0;
    state_nxt      = state_r;
    len_nxt        = len_r;
    kind_nxt       = kind_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    ptr_nxt        = ptr_r;
    rem_nxt        = rem_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    out_found_nxt  = out_found_r;
    out_len_nxt    = out_len_r;
    mem_we         = 1'b0;
    mem_waddr      = pend_addr_r;
    mem_wdata      = mem_rdata;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt       = in_kind;
          pos_nxt        = in_position;
          val_nxt        = in_value;
          out_status_nxt = ale_pkg::ST_OK;
          out_rd_nxt     = '0;
          out_found_nxt  = '0;
          case (in_kind)
            ale_pkg::KIND_GET: begin
              if (pos_zero || pos_over) begin
                fin            = 1'b1;
                out_status_nxt = ale_pkg::ST_BAD_POS;
              end else begin
                ptr_nxt   = posm1[AW-1:0];
                state_nxt = S_GET_RD;
              end
            end
            ale_pkg::KIND_LOCATE: begin
              ptr_nxt   = '0;
              rem_nxt   = len_r;
              state_nxt = S_LOC;
            end
            ale_pkg::KIND_INSERT: begin
              if (pos_zero || ins_over) begin
                fin            = 1'b1;
                out_status_nxt = ale_pkg::ST_BAD_POS;
              end else if (list_full) begin
                fin            = 1'b1;
                out_status_nxt = ale_pkg::ST_FULL;
              end else begin
                // walk down from the last entry, moving each one up
                ptr_nxt   = lenm1[AW-1:0];
                rem_nxt   = ins_moves[LW-1:0];
                state_nxt = S_SHIFT;
              end
            end
            default: begin
              if (pos_zero || pos_over) begin
                fin            = 1'b1;
                out_status_nxt = ale_pkg::ST_BAD_POS;
              end else begin
                // walk up from the entry after the hole, moving each down
                ptr_nxt   = posw[AW-1:0];
                rem_nxt   = del_moves[LW-1:0];
                state_nxt = S_SHIFT;
              end
            end
          endcase
        end
      end

      S_GET_RD: begin
        state_nxt = S_GET_OUT;
      end

      S_GET_OUT: begin
        fin        = 1'b1;
        out_rd_nxt = mem_rdata;
      end

      // one read issued per cycle, compared the cycle after
      S_LOC: begin
        if (pend_r && (mem_rdata == val_r)) begin
          fin           = 1'b1;
          out_found_nxt = found_w[ale_pkg::POS_W-1:0];
        end else if (rem_r != '0) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r;
          ptr_nxt       = ptr_r + AW'(1);
          rem_nxt       = rem_r - LW'(1);
        end else if (!pend_r) begin
          fin            = 1'b1;
          out_status_nxt = ale_pkg::ST_NOT_FOUND;
        end
      end

      // read one entry, write it one place over in the next cycle
      S_SHIFT: begin
        if (pend_r) begin
          mem_we = 1'b1;
          if (kind_r == ale_pkg::KIND_INSERT) begin
            mem_waddr = pend_addr_r + AW'(1);
          end else begin
            mem_waddr = pend_addr_r - AW'(1);
          end
        end
        if (rem_r != '0) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r;
          rem_nxt       = rem_r - LW'(1);
          if (kind_r == ale_pkg::KIND_INSERT) begin
            ptr_nxt = ptr_r - AW'(1);
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end else if (!pend_r) begin
          if (kind_r == ale_pkg::KIND_INSERT) begin
            state_nxt = S_FILL;
          end else begin
            fin     = 1'b1;
            fin_len = len_r - LW'(1);
          end
        end
      end

      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r_m1[AW-1:0];
        mem_wdata = val_r;
        fin       = 1'b1;
        fin_len   = len_r + LW'(1);
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result strobe and length update
    if (fin) begin
      fin_len_w     = CW'(fin_len);
      state_nxt     = S_IDLE;
      len_nxt       = fin_len;
      out_valid_nxt = 1'b1;
      out_len_nxt   = fin_len_w[ale_pkg::POS_W-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    ptr_r        <= ptr_nxt;
    rem_r        <= rem_nxt;
    pend_addr_r  <= pend_addr_nxt;
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_found_r  <= out_found_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_value     = out_rd_r;
  assign out_found_position = out_found_r;
  assign out_length         = out_len_r;

endmodule

/* src/ale_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module ale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
